// ----- hdl/pbrv_pkg.sv -----
// Package for the per-bin running variance unit.
// Holds the sequencer states, field widths and the stored entry layout.
// No dependencies.
package pbrv_pkg;

   localparam int BIN_W   = 8;
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W = 32;
   localparam int MEAN_W  = 32;
   localparam int M2_W    = 64;
   localparam int VAR_W   = 64;
   localparam int STD_W   = 32;
   localparam int ENTRY_W = COUNT_W + MEAN_W + M2_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 168;

   // One stored bin entry
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [MEAN_W-1:0]  mean;
      logic [M2_W-1:0]    m2;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_DIVM,
      ST_MUL,
      ST_ACC,
      ST_DIVV,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/per_bin_running_variance_unit.sv -----
// Top level of the per-bin running variance unit.
// Depends on pbrv_pkg and pbrv_ram.
//
// Keeps a Welford count, mean and second moment for each of NUM_BINS bins in
// one RAM and returns count, mean, variance and standard deviation for every
// sample. After reset the RAM is swept to zero, one entry a cycle, and the
// block takes no request until the sweep is done. One item is worked at a time.
// The first sample of a bin goes from the load state straight to the output
// state. A later sample passes a load state, a shared one-bit-a-cycle divider
// (32 steps for the mean, 64 for the variance), a multiply state and an
// accumulate state, a 32-step square root and the output state. The next
// request is taken in the cycle after the result is registered, so no new
// sample is taken while one is being worked. A bin index of NUM_BINS or more
// returns its bin with zero count, mean, variance and deviation and leaves
// the store unchanged. The result sits in an output register, so a waiting
// result does not stop work on the next request.
module per_bin_running_variance_unit #(
   parameter int NUM_BINS = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [pbrv_pkg::REQ_DATA_W-1:0] req_tdata, // bin_index, sample_value
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_bin, sample_count, running_mean, running_variance, std_deviation
   output logic [pbrv_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pbrv_pkg::*;

   localparam int IDX_W = $clog2(NUM_BINS > 1 ? NUM_BINS : 2);

   state_type state_ff, state_in;

   logic [BIN_W-1:0]    bin_ff;
   logic [SAMPLE_W-1:0] x_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic                neg_ff;
   logic [31:0]         dmag_ff;
   logic [M2_W-1:0]     m2_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         dvd_ff;
   logic [31:0]         rem_ff;
   logic [31:0]         dsr_ff;
   logic [5:0]          iter_ff;
   logic [VAR_W-1:0]    var_ff;
   logic [63:0]         sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [STD_W-1:0]    sd_ff;
   logic [IDX_W-1:0]    clr_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic req_fire, rsp_free, oor;
   logic [BIN_W-1:0]    req_bin;
   logic [SAMPLE_W-1:0] req_x;
   logic [IDX_W+BIN_W-1:0] req_ext, bin_ext;
   entry_type rd_entry, wr_entry;
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [COUNT_W-1:0] n_new;
   logic [MEAN_W-1:0]  old_mean, new_mean;
   logic [31:0] rmag, step_q;
   logic [64:0] m2_sum;
   logic [M2_W-1:0] m2_new;
   logic [32:0] div_t, div_diff;
   logic        div_ge;
   logic [31:0] rem_next;
   logic [63:0] dvd_next;
   logic [63:0] sq_trial, sq_v_next, sq_res_next;
   logic        sq_ge;

   assign req_bin  = req_tdata[7:0];
   assign req_x    = req_tdata[39:8];
   assign req_ext  = {{IDX_W{1'b0}}, req_bin};
   assign bin_ext  = {{IDX_W{1'b0}}, bin_ff};
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign oor      = 32'(req_bin) >= 32'(NUM_BINS);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Entry store
   pbrv_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BINS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(wr_entry),
      .rd_addr(ram_raddr),
      .rd_data(rd_entry)
   );

   // Count, mean and moment arithmetic
   always_comb begin
      old_mean = rd_entry.mean;
      n_new    = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 32'd1;
      step_q   = dvd_ff[31:0];
      new_mean = neg_ff ? mean_ff - step_q : mean_ff + step_q;
      rmag     = neg_ff ? new_mean - x_ff : x_ff - new_mean;
      m2_sum   = {1'b0, m2_ff} + {1'b0, prod_ff};
      m2_new   = m2_sum[64] ? '1 : m2_sum[63:0];
   end

   // Restoring divider step, one quotient bit a cycle
   always_comb begin
      div_t    = {rem_ff, dvd_ff[63]};
      div_diff = div_t - {1'b0, dsr_ff};
      div_ge   = !div_diff[32];
      rem_next = div_ge ? div_diff[31:0] : div_t[31:0];
      dvd_next = {dvd_ff[62:0], div_ge};
   end

   // Square root step, two radicand bits a cycle
   always_comb begin
      sq_trial    = sq_res_ff + sq_bit_ff;
      sq_ge       = sq_v_ff >= sq_trial;
      sq_v_next   = sq_ge ? sq_v_ff - sq_trial : sq_v_ff;
      sq_res_next = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (32'(clr_ff) == NUM_BINS - 1) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = oor ? ST_DONE : ST_LOAD;
         ST_LOAD:  state_in = (n_new == 32'd1) ? ST_DONE : ST_DIVM;
         ST_DIVM:  if (iter_ff == '0) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_DIVV;
         ST_DIVV:  if (iter_ff == '0) state_in = ST_ROOT;
         ST_ROOT:  if (iter_ff == '0) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // RAM port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = bin_ext[IDX_W-1:0];
      ram_raddr = req_ext[IDX_W-1:0];
      wr_entry  = '{count: cnt_ff, mean: mean_ff, m2: m2_new};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            wr_entry  = '0;
         end
         ST_LOAD: begin
            ram_we   = (n_new == 32'd1);
            wr_entry = '{count: n_new, mean: x_ff, m2: '0};
         end
         ST_ACC:  ram_we = 1'b1;
         default: ram_we = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            bin_ff  <= req_bin;
            x_ff    <= req_x;
            cnt_ff  <= '0;
            mean_ff <= '0;
            var_ff  <= '0;
            sd_ff   <= '0;
         end
         ST_LOAD: begin
            cnt_ff  <= n_new;
            mean_ff <= (n_new == 32'd1) ? x_ff : old_mean;
            neg_ff  <= x_ff < old_mean;
            dmag_ff <= (x_ff < old_mean) ? old_mean - x_ff : x_ff - old_mean;
            dvd_ff  <= {((x_ff < old_mean) ? old_mean - x_ff : x_ff - old_mean), 32'd0};
            rem_ff  <= '0;
            dsr_ff  <= n_new;
            m2_ff   <= rd_entry.m2;
            iter_ff <= 6'd31;
         end
         ST_DIVM: begin
            dvd_ff  <= dvd_next;
            rem_ff  <= rem_next;
            iter_ff <= iter_ff - 1'b1;
         end
         ST_MUL: begin
            mean_ff <= new_mean;
            prod_ff <= 64'(dmag_ff) * 64'(rmag);
         end
         ST_ACC: begin
            m2_ff   <= m2_new;
            dvd_ff  <= m2_new;
            rem_ff  <= '0;
            dsr_ff  <= cnt_ff - 32'd1;
            iter_ff <= 6'd63;
         end
         ST_DIVV: begin
            dvd_ff  <= dvd_next;
            rem_ff  <= rem_next;
            if (iter_ff == '0) begin
               var_ff    <= dvd_next;
               sq_v_ff   <= dvd_next;
               sq_res_ff <= '0;
               sq_bit_ff <= 64'd1 << 62;
               iter_ff   <= 6'd31;
            end else begin
               iter_ff   <= iter_ff - 1'b1;
            end
         end
         ST_ROOT: begin
            sq_v_ff   <= sq_v_next;
            sq_res_ff <= sq_res_next;
            sq_bit_ff <= sq_bit_ff >> 2;
            iter_ff   <= iter_ff - 1'b1;
            if (iter_ff == '0) sd_ff <= sq_res_next[31:0];
         end
         ST_DONE: begin
            if (rsp_free) rsp_data_ff <= {sd_ff, var_ff, mean_ff, cnt_ff, bin_ff};
         end
         default: begin
            iter_ff <= iter_ff;
         end
      endcase
   end

endmodule

// ----- hdl/pbrv_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pbrv_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word and read one word, with the read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
